[rtl/core/pairwise_wealth_exchange_sim_unit_defines.svh]
// Assertion macros for the pairwise wealth exchange unit.
`ifndef PAIRWISE_WEALTH_EXCHANGE_SIM_UNIT_DEFINES_SVH
`define PAIRWISE_WEALTH_EXCHANGE_SIM_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwe assertion failed");
`define PWE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwe assertion failed");
`else
`define PWE_ASSERT_IMP(lbl, ante, cons)
`define PWE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/pwe_pkg.sv]
// Shared constants, codes and controller/datapath types of the wealth exchange unit.
package pwe_pkg;

  localparam int MAX_AGENTS = 16;
  localparam int IDX_W      = $clog2(MAX_AGENTS);
  localparam int CNT_W      = $clog2(MAX_AGENTS + 1);

  localparam int VAL_W  = 21;
  localparam int FRAC_W = 16;
  localparam int KIND_W = 2;
  localparam int AGT_W  = 4;
  localparam int COIN_W = 16;
  localparam int OC_W   = 2;
  localparam int SHR_W  = 17;
  localparam int POP_W  = 5;
  localparam int TF_W   = 17;
  localparam int BIAS_W = 16;
  localparam int PR_W   = 11;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W  = 2;

  localparam int TOT_W  = VAL_W + CNT_W;
  localparam int WGT_W  = VAL_W + 2 * CNT_W;
  localparam int POS_W  = WGT_W + 1;
  localparam int DVS_W  = POS_W;
  localparam int POOL_W = FRAC_W + CNT_W;
  localparam int Q_W    = POOL_W;
  localparam int STEP_W = $clog2(Q_W + 1);
  localparam int SUM_W  = ((POOL_W > VAL_W) ? POOL_W : VAL_W) + 1;
  localparam int TK_W   = VAL_W + PR_W - FRAC_W;

  localparam logic [VAL_W-1:0] VALUE_MAX = '1;
  localparam logic [VAL_W-1:0] ONE_Q16   = VAL_W'(1) << FRAC_W;
  localparam logic [SHR_W-1:0] SHR_ONE   = SHR_W'(1) << FRAC_W;

  localparam logic [KIND_W-1:0] KIND_EXCHANGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET    = 2'd2;

  localparam logic [OC_W-1:0] OC_FIRST  = 2'd0;
  localparam logic [OC_W-1:0] OC_SECOND = 2'd1;
  localparam logic [OC_W-1:0] OC_SKIP   = 2'd2;
  localparam logic [OC_W-1:0] OC_NONE   = 2'd3;

  localparam logic [REG_W-1:0] REG_POPULATION = 2'd0;
  localparam logic [REG_W-1:0] REG_TRADE_FRAC = 2'd1;
  localparam logic [REG_W-1:0] REG_BIAS       = 2'd2;
  localparam logic [REG_W-1:0] REG_POOL_RATE  = 2'd3;

  typedef enum logic [1:0] {
    DIV_SHARE,
    DIV_TOP,
    DIV_GINI
  } div_sel_e;

  typedef struct packed {
    logic     cap_in;
    logic     rd_pair;
    logic     ex_lat;
    logic     ex_skip;
    logic     ex_upd;
    logic     wr_a;
    logic     wr_b;
    logic     clr_all;
    logic     idx_clr;
    logic     idx_inc;
    logic     pool_wr;
    logic     acc_wr;
    logic     rk_cnt;
    logic     rk_acc;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     gi_prep;
    logic     res_load;
  } pwe_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_bad;
    logic              stake_zero;
    logic              idx_last;
    logic              div_busy;
    logic              total_zero;
    logic              gini_pos;
    logic              out_busy;
  } pwe_sts_t;

endpackage

[rtl/core/pwe_in_if.sv]
// Input item channel of the wealth exchange unit.
interface pwe_in_if import pwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [AGT_W-1:0]  first_agent;
  logic [AGT_W-1:0]  second_agent;
  logic [COIN_W-1:0] coin;

  modport source (output valid, kind, first_agent, second_agent, coin, input ready);
  modport sink (input valid, kind, first_agent, second_agent, coin, output ready);
endinterface

[rtl/core/pwe_out_if.sv]
// Result item channel of the wealth exchange unit.
interface pwe_out_if import pwe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] first_value;
  logic [VAL_W-1:0] second_value;
  logic [OC_W-1:0]  outcome;
  logic [SHR_W-1:0] top_share;
  logic [SHR_W-1:0] gini_index;
  logic             concentrated;

  modport source (output valid, first_value, second_value, outcome, top_share, gini_index,
                  concentrated, input ready);
  modport sink (input valid, first_value, second_value, outcome, top_share, gini_index,
                concentrated, output ready);
endinterface

[rtl/core/pwe_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the tick statistics.
module pwe_div import pwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVS_W-1:0]  dvs_i,
  input  logic [DVS_W-1:0]  rem_i,
  input  logic [Q_W-1:0]    low_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              busy_o,
  output logic [Q_W-1:0]    quo_o
);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVS_W-1:0]  dvs_q, rem_q;
  logic [Q_W-1:0]    low_q, quo_q;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, low_q[Q_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && cnt_q == STEP_W'(1)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= dvs_i;
      rem_q <= rem_i;
      low_q <= low_i;
      quo_q <= '0;
      cnt_q <= steps_i;
    end else if (busy_q) begin
      rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      low_q <= {low_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/pwe_dp.sv]
// Datapath: agent value memory, exchange arithmetic, tick passes and result register.
module pwe_dp import pwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwe_cmd_t          cmd_i,
  output pwe_sts_t          sts_o,
  input  logic [CNT_W-1:0]  n_i,
  input  logic [TF_W-1:0]   tf_i,
  input  logic [BIAS_W-1:0] bias_i,
  input  logic [PR_W-1:0]   pr_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [AGT_W-1:0]  first_agent_i,
  input  logic [AGT_W-1:0]  second_agent_i,
  input  logic [COIN_W-1:0] coin_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  first_value_o,
  output logic [VAL_W-1:0]  second_value_o,
  output logic [OC_W-1:0]   outcome_o,
  output logic [SHR_W-1:0]  top_share_o,
  output logic [SHR_W-1:0]  gini_index_o,
  output logic              concentrated_o
);

  logic [VAL_W-1:0]  mem [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] vld_q;
  logic [VAL_W-1:0]  rda_q, rdb_q;

  logic [KIND_W-1:0] kind_q;
  logic [AGT_W-1:0]  a_q, b_q;
  logic [COIN_W-1:0] coin_q;
  logic [VAL_W-1:0]  va_q, vb_q, stake_q, fv_q, sv_q;
  logic [OC_W-1:0]   oc_q;
  logic [IDX_W-1:0]  idx_q;
  logic [POOL_W-1:0] pool_q, share_q;
  logic [TOT_W-1:0]  total_q;
  logic [VAL_W-1:0]  mx_q, cur_q;
  logic [VAL_W-1:0]  snap_q [MAX_AGENTS];
  logic [CNT_W-1:0]  rank_q;
  logic [WGT_W-1:0]  wgt_q;
  logic [POS_W-1:0]  pos_q, neg_q;
  logic [DVS_W-1:0]  nt_q;
  logic [SHR_W-1:0]  top_q, gini_q;
  logic              out_valid_q;

  logic [IDX_W-1:0]        ra, rb, waddr;
  logic                    wen;
  logic [VAL_W-1:0]        wdata, lo, stake, nva, nvb, accv;
  logic [TF_W+VAL_W-1:0]   stake_full;
  logic [SHR_W-1:0]        pwin;
  logic                    win;
  logic [VAL_W:0]          sum_a, sum_b;
  logic [VAL_W+PR_W-1:0]   tk_full;
  logic [TK_W-1:0]         tk;
  logic [SUM_W-1:0]        acc_sum;
  logic [CNT_W-1:0]        rank;
  logic [POS_W-1:0]        diff;
  logic [DVS_W-1:0]        div_dvs, div_rem;
  logic [Q_W-1:0]          div_low, quo;
  logic [STEP_W-1:0]       div_steps;
  logic                    div_busy;
  logic [SHR_W-1:0]        quo_clamp;

  // Memory ports
  assign ra = cmd_i.rd_pair ? IDX_W'(a_q) : idx_q;
  assign rb = IDX_W'(b_q);

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rda_q <= vld_q[ra] ? mem[ra] : ONE_Q16;
    rdb_q <= vld_q[rb] ? mem[rb] : ONE_Q16;
  end

  // Unwritten entries read as 1.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.clr_all) begin
      vld_q <= '0;
    end else if (wen) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  // Exchange arithmetic
  always_comb begin
    lo         = (rda_q < rdb_q) ? rda_q : rdb_q;
    stake_full = tf_i * lo;
    stake      = VAL_W'(stake_full >> FRAC_W);
    if (va_q > vb_q) begin
      pwin = SHR_W'(32768) + SHR_W'(bias_i);
    end else if (va_q < vb_q) begin
      pwin = SHR_W'(32768) - SHR_W'(bias_i);
    end else begin
      pwin = SHR_W'(32768);
    end
    win   = SHR_W'(coin_q) < pwin;
    sum_a = {1'b0, va_q} + {1'b0, stake_q};
    sum_b = {1'b0, vb_q} + {1'b0, stake_q};
    if (win) begin
      nva = sum_a[VAL_W] ? VALUE_MAX : sum_a[VAL_W-1:0];
      nvb = (vb_q >= stake_q) ? vb_q - stake_q : '0;
    end else begin
      nva = (va_q >= stake_q) ? va_q - stake_q : '0;
      nvb = sum_b[VAL_W] ? VALUE_MAX : sum_b[VAL_W-1:0];
    end
  end

  // Tick arithmetic
  always_comb begin
    tk_full = rda_q * pr_i;
    tk      = TK_W'(tk_full >> FRAC_W);
    acc_sum = SUM_W'(rda_q) + SUM_W'(share_q);
    accv    = (acc_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : VAL_W'(acc_sum);
  end

  // Rank of the current value among the active ones; ties broken by index
  always_comb begin
    rank = CNT_W'(1);
    for (int j = 0; j < MAX_AGENTS; j++) begin
      if (CNT_W'(j) < n_i) begin
        if ((IDX_W'(j) < idx_q && snap_q[j] <= snap_q[idx_q]) ||
            (IDX_W'(j) > idx_q && snap_q[j] < snap_q[idx_q])) begin
          rank = rank + 1'b1;
        end
      end
    end
  end

  always_comb begin
    wen   = cmd_i.wr_a | cmd_i.wr_b | cmd_i.pool_wr | cmd_i.acc_wr;
    waddr = idx_q;
    wdata = accv;
    if (cmd_i.wr_a) begin
      waddr = IDX_W'(a_q);
      wdata = fv_q;
    end else if (cmd_i.wr_b) begin
      waddr = IDX_W'(b_q);
      wdata = sv_q;
    end else if (cmd_i.pool_wr) begin
      wdata = rda_q - VAL_W'(tk);
    end
  end

  // Divider operands
  assign diff = pos_q - neg_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SHARE: begin
        div_dvs   = DVS_W'(n_i);
        div_rem   = '0;
        div_low   = Q_W'(pool_q);
        div_steps = STEP_W'(Q_W);
      end
      DIV_TOP: begin
        div_dvs   = DVS_W'(total_q);
        div_rem   = DVS_W'(mx_q >> 1);
        div_low   = Q_W'(mx_q[0]) << (Q_W - 1);
        div_steps = STEP_W'(FRAC_W + 1);
      end
      DIV_GINI: begin
        div_dvs   = nt_q;
        div_rem   = DVS_W'(diff >> 1);
        div_low   = Q_W'(diff[0]) << (Q_W - 1);
        div_steps = STEP_W'(FRAC_W + 1);
      end
      default: begin
        div_dvs   = '1;
        div_rem   = '0;
        div_low   = '0;
        div_steps = '0;
      end
    endcase
  end

  pwe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .dvs_i  (div_dvs),
    .rem_i  (div_rem),
    .low_i  (div_low),
    .steps_i(div_steps),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  assign quo_clamp = (quo > Q_W'(SHR_ONE)) ? SHR_ONE : SHR_W'(quo);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      kind_q  <= kind_i;
      a_q     <= first_agent_i;
      b_q     <= second_agent_i;
      coin_q  <= coin_i;
      fv_q    <= '0;
      sv_q    <= '0;
      oc_q    <= OC_NONE;
      top_q   <= '0;
      gini_q  <= '0;
      pool_q  <= '0;
      total_q <= '0;
      mx_q    <= '0;
      wgt_q   <= '0;
    end
    if (cmd_i.ex_lat) begin
      va_q    <= rda_q;
      vb_q    <= rdb_q;
      stake_q <= stake;
    end
    if (cmd_i.ex_skip) begin
      oc_q <= OC_SKIP;
    end
    if (cmd_i.ex_upd) begin
      fv_q <= nva;
      sv_q <= nvb;
      oc_q <= win ? OC_FIRST : OC_SECOND;
    end
    if (cmd_i.cap_in || cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.pool_wr) begin
      pool_q <= pool_q + POOL_W'(tk);
    end
    if (cmd_i.acc_wr) begin
      snap_q[idx_q] <= accv;
      total_q       <= total_q + TOT_W'(accv);
      if (accv > mx_q) begin
        mx_q <= accv;
      end
    end
    if (cmd_i.rk_cnt) begin
      rank_q <= rank;
      cur_q  <= snap_q[idx_q];
    end
    if (cmd_i.rk_acc) begin
      wgt_q <= wgt_q + WGT_W'(cur_q * rank_q);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_SHARE: share_q <= POOL_W'(quo);
        DIV_TOP:   top_q   <= quo_clamp;
        DIV_GINI:  gini_q  <= quo_clamp;
        default:   ;
      endcase
    end
    if (cmd_i.gi_prep) begin
      pos_q <= {wgt_q, 1'b0};
      neg_q <= POS_W'((n_i + 1'b1) * total_q);
      nt_q  <= DVS_W'(n_i * total_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      first_value_o  <= fv_q;
      second_value_o <= sv_q;
      outcome_o      <= oc_q;
      top_share_o    <= top_q;
      gini_index_o   <= gini_q;
      concentrated_o <= top_q[FRAC_W] | top_q[FRAC_W-1];
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.idx_bad    = (a_q == b_q) || (CNT_W'(a_q) >= n_i) || (CNT_W'(b_q) >= n_i);
    sts_o.stake_zero = (stake_q == '0);
    sts_o.idx_last   = (CNT_W'(idx_q) == n_i - 1'b1);
    sts_o.div_busy   = div_busy;
    sts_o.total_zero = (total_q == '0);
    sts_o.gini_pos   = (pos_q > neg_q);
    sts_o.out_busy   = out_valid_q & ~out_ready_i;
  end

endmodule

[rtl/core/pwe_ctrl.sv]
// Controller: sequences exchange, tick and reset items over the datapath.
module pwe_ctrl import pwe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output pwe_cmd_t cmd_o,
  input  pwe_sts_t sts_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_EX_RD, S_EX_LAT, S_EX_UPD, S_EX_WA, S_EX_WB, S_CLR,
    S_PL_RD, S_PL_WR, S_SH_GO, S_SH_WT, S_AC_RD, S_AC_WR, S_RK_CNT, S_RK_ACC,
    S_ST_CHK, S_TP_GO, S_TP_WT, S_GI_PREP, S_GI_CHK, S_GI_GO, S_GI_WT, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.kind)
          KIND_EXCHANGE: state_d = S_EX_RD;
          KIND_TICK:     state_d = S_PL_RD;
          KIND_RESET:    state_d = S_CLR;
          default:       state_d = S_DONE;
        endcase
      end
      S_EX_RD: begin
        if (sts_i.idx_bad) begin
          cmd_o.ex_skip = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_pair = 1'b1;
          state_d       = S_EX_LAT;
        end
      end
      S_EX_LAT: begin
        cmd_o.ex_lat = 1'b1;
        state_d      = S_EX_UPD;
      end
      S_EX_UPD: begin
        if (sts_i.stake_zero) begin
          cmd_o.ex_skip = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.ex_upd = 1'b1;
          state_d      = S_EX_WA;
        end
      end
      S_EX_WA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = S_EX_WB;
      end
      S_EX_WB: begin
        cmd_o.wr_b = 1'b1;
        state_d    = S_DONE;
      end
      S_CLR: begin
        cmd_o.clr_all = 1'b1;
        state_d       = S_DONE;
      end
      // Pool pass: take a share from each active agent
      S_PL_RD: state_d = S_PL_WR;
      S_PL_WR: begin
        cmd_o.pool_wr = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SH_GO;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_PL_RD;
        end
      end
      S_SH_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SHARE;
        state_d         = S_SH_WT;
      end
      S_SH_WT: begin
        cmd_o.div_sel = DIV_SHARE;
        if (!sts_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          state_d        = S_AC_RD;
        end
      end
      // Payout pass: add the share, snapshot values, total and maximum
      S_AC_RD: state_d = S_AC_WR;
      S_AC_WR: begin
        cmd_o.acc_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_RK_CNT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_AC_RD;
        end
      end
      S_RK_CNT: begin
        cmd_o.rk_cnt = 1'b1;
        state_d      = S_RK_ACC;
      end
      S_RK_ACC: begin
        cmd_o.rk_acc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_ST_CHK;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RK_CNT;
        end
      end
      S_ST_CHK: state_d = sts_i.total_zero ? S_DONE : S_TP_GO;
      S_TP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_TOP;
        state_d         = S_TP_WT;
      end
      S_TP_WT: begin
        cmd_o.div_sel = DIV_TOP;
        if (!sts_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_GI_PREP;
        end
      end
      S_GI_PREP: begin
        cmd_o.gi_prep = 1'b1;
        state_d       = S_GI_CHK;
      end
      S_GI_CHK: state_d = sts_i.gini_pos ? S_GI_GO : S_DONE;
      S_GI_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_GINI;
        state_d         = S_GI_WT;
      end
      S_GI_WT: begin
        cmd_o.div_sel = DIV_GINI;
        if (!sts_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/core/pairwise_wealth_exchange_sim_unit.sv]
// An exchange reads both agents, latches them, updates and writes back both values; a
// skipped exchange stops at the index or stake check; a reset clears the valid bits. A tick
// makes three passes over the agents and a share division plus up to two more on one divider.
// One item is in work at a time; the next is taken while the last result waits.
// Reset is asynchronous and active low: control registers take their defaults and every
// agent reads 1.0 at once through cleared valid bits, with no clearing pass.
`include "pairwise_wealth_exchange_sim_unit_defines.svh"
module pairwise_wealth_exchange_sim_unit import pwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pwe_in_if.sink            in_if,
  pwe_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [TF_W-1:0] TF_MIN   = TF_W'(66);
  localparam logic [TF_W-1:0] TF_MAX   = TF_W'(65536);
  localparam logic [BIAS_W-1:0] BIAS_MAX = BIAS_W'(32768);
  localparam logic [PR_W-1:0] PR_MAX   = PR_W'(1311);

  logic [POP_W-1:0]  pop_q;
  logic [TF_W-1:0]   tf_q;
  logic [BIAS_W-1:0] bias_q;
  logic [PR_W-1:0]   pr_q;
  logic [REG_W-1:0]  reg_idx;
  logic              wr_en;

  logic [CNT_W-1:0]  n_use;
  logic [TF_W-1:0]   tf_use;
  logic [BIAS_W-1:0] bias_use;
  logic [PR_W-1:0]   pr_use;

  pwe_cmd_t cmd;
  pwe_sts_t sts;
  logic     in_ready;
  logic     in_acc;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q  <= POP_W'(16);
      tf_q   <= TF_W'(6554);
      bias_q <= '0;
      pr_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POPULATION: pop_q  <= pwdata[POP_W-1:0];
        REG_TRADE_FRAC: tf_q   <= pwdata[TF_W-1:0];
        REG_BIAS:       bias_q <= pwdata[BIAS_W-1:0];
        REG_POOL_RATE:  pr_q   <= pwdata[PR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POPULATION: prdata = DATA_W'(pop_q);
      REG_TRADE_FRAC: prdata = DATA_W'(tf_q);
      REG_BIAS:       prdata = DATA_W'(bias_q);
      REG_POOL_RATE:  prdata = DATA_W'(pr_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp the registers to their working ranges
  always_comb begin
    if (pop_q < POP_W'(2)) begin
      n_use = CNT_W'(2);
    end else if (pop_q > POP_W'(MAX_AGENTS)) begin
      n_use = CNT_W'(MAX_AGENTS);
    end else begin
      n_use = CNT_W'(pop_q);
    end
    if (tf_q < TF_MIN) begin
      tf_use = TF_MIN;
    end else if (tf_q > TF_MAX) begin
      tf_use = TF_MAX;
    end else begin
      tf_use = tf_q;
    end
    bias_use = (bias_q > BIAS_MAX) ? BIAS_MAX : bias_q;
    pr_use   = (pr_q > PR_MAX) ? PR_MAX : pr_q;
  end

  assign in_if.ready = in_ready;
  assign in_acc      = in_if.valid & in_ready;

  pwe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  pwe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .n_i           (n_use),
    .tf_i          (tf_use),
    .bias_i        (bias_use),
    .pr_i          (pr_use),
    .kind_i        (in_if.kind),
    .first_agent_i (in_if.first_agent),
    .second_agent_i(in_if.second_agent),
    .coin_i        (in_if.coin),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .first_value_o (out_if.first_value),
    .second_value_o(out_if.second_value),
    .outcome_o     (out_if.outcome),
    .top_share_o   (out_if.top_share),
    .gini_index_o  (out_if.gini_index),
    .concentrated_o(out_if.concentrated)
  );

  `PWE_ASSERT_IMP(a_div_not_restarted, cmd.div_start, !sts.div_busy)
  `PWE_ASSERT_IMP(a_single_write, 1'b1, $onehot0({cmd.wr_a, cmd.wr_b, cmd.pool_wr, cmd.acc_wr}))
  `PWE_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready)

endmodule
